>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on i_clk and
// is switched off while the synchronous reset i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/b64sc_pkg.sv
package b64sc_pkg;

    // Results one request can cause: a byte that opens a group and ends the message.
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // One queued work entry: the result bytes of one request, oldest first.
    typedef struct packed {
        logic [CNT_W-1:0]             count;
        logic [MAX_RESULTS-1:0][7:0]  data;
    } t_entry;

    // Six-bit symbol to alphabet character.
    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            sym_char = w + CHAR_UC_A;
        end else if (v < 6'd52) begin
            sym_char = w + (CHAR_LC_A - 8'd26);
        end else if (v < 6'd62) begin
            sym_char = w - (8'd52 - CHAR_0);
        end else if (v == 6'd62) begin
            sym_char = CHAR_PLUS;
        end else begin
            sym_char = CHAR_SLASH;
        end
    endfunction

    // Character to six-bit symbol; anything outside the alphabet maps to 63.
    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        case (c) inside
            [CHAR_UC_A:CHAR_UC_Z]: d = c - CHAR_UC_A;
            [CHAR_LC_A:CHAR_LC_Z]: d = c - CHAR_LC_A + 8'd26;
            [CHAR_0:CHAR_9]:       d = c - CHAR_0 + 8'd52;
            CHAR_PLUS:             d = 8'd62;
            default:               d = 8'd63;
        endcase
        char_value = d[5:0];
    endfunction

endpackage

>>> rtl/core/b64sc_in_if.sv
interface b64sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> rtl/core/b64sc_out_if.sv
interface b64sc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> rtl/core/b64sc_front.sv
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    input  logic       i_push_ready,
    output t_entry     o_entry
);

    logic       r_dir;
    logic [1:0] r_pos;
    logic [5:0] r_lo;
    logic       r_pad;
    logic [1:0] n_pos;
    logic [5:0] n_lo;
    logic       n_pad;
    logic [1:0] pos_e;
    logic [5:0] v;
    logic       accept;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;
    assign o_push  = accept && (o_entry.count != '0);
    assign pos_e   = (r_pos == 2'd3) ? 2'd0 : r_pos;
    assign v       = char_value(i_byte);

    always_comb begin
        n_pos         = r_pos;
        n_lo          = r_lo;
        n_pad         = r_pad;
        o_entry.count = '0;
        o_entry.data  = '0;
        if (r_dir == DIR_ENCODE) begin
            case (pos_e)
                2'd0: begin
                    o_entry.data[0] = sym_char(i_byte[7:2]);
                    o_entry.count   = CNT_W'(1);
                    n_lo            = {i_byte[1:0], 4'b0000};
                    n_pos           = 2'd1;
                end
                2'd1: begin
                    o_entry.data[0] = sym_char({r_lo[5:4], i_byte[7:4]});
                    o_entry.count   = CNT_W'(1);
                    n_lo            = {i_byte[3:0], 2'b00};
                    n_pos           = 2'd2;
                end
                default: begin
                    o_entry.data[0] = sym_char({r_lo[5:2], i_byte[7:6]});
                    o_entry.data[1] = sym_char(i_byte[5:0]);
                    o_entry.count   = CNT_W'(2);
                    n_lo            = '0;
                    n_pos           = 2'd0;
                end
            endcase
            if (i_last) begin
                // Flush the partial group: leftover bits, then padding.
                if (n_pos == 2'd1) begin
                    o_entry.data[1] = sym_char(n_lo);
                    o_entry.data[2] = CHAR_PAD;
                    o_entry.data[3] = CHAR_PAD;
                    o_entry.count   = CNT_W'(4);
                end else if (n_pos == 2'd2) begin
                    o_entry.data[1] = sym_char(n_lo);
                    o_entry.data[2] = CHAR_PAD;
                    o_entry.count   = CNT_W'(3);
                end
            end
        end else begin
            if (!r_pad) begin
                if (r_pos == 2'd0) begin
                    n_lo  = v;
                    n_pos = 2'd1;
                end else if (r_pos == 2'd1) begin
                    o_entry.data[0] = {r_lo, v[5:4]};
                    o_entry.count   = CNT_W'(1);
                    n_lo            = {2'b00, v[3:0]};
                    n_pos           = 2'd2;
                end else if (i_byte == CHAR_PAD) begin
                    n_pad = 1'b1;
                end else if (r_pos == 2'd2) begin
                    o_entry.data[0] = {r_lo[3:0], v[5:2]};
                    o_entry.count   = CNT_W'(1);
                    n_lo            = {4'b0000, v[1:0]};
                    n_pos           = 2'd3;
                end else begin
                    o_entry.data[0] = {r_lo[1:0], v};
                    o_entry.count   = CNT_W'(1);
                    n_lo            = '0;
                    n_pos           = 2'd0;
                end
            end
        end
        if (i_last) begin
            n_pos = 2'd0;
            n_lo  = '0;
            n_pad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
            r_pos <= '0;
            r_lo  <= '0;
            r_pad <= 1'b0;
        end else if (i_cfg_we) begin
            r_dir <= i_cfg_wdata;
            r_pos <= '0;
            r_lo  <= '0;
            r_pad <= 1'b0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_lo  <= n_lo;
            r_pad <= n_pad;
        end
    end

endmodule

>>> rtl/core/b64sc_queue.sv
module b64sc_queue
    import b64sc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_push_ready,
    input  t_entry i_entry,
    output logic   o_valid,
    input  logic   i_pop,
    output t_entry o_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_Q = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_Q-1:0]   r_fill;

    assign o_push_ready = (r_fill != CNT_Q'(DEPTH));
    assign o_valid      = (r_fill != '0);
    assign o_entry      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/b64sc_back.sv
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    localparam int unsigned IDX_W = $clog2(MAX_RESULTS);

    logic [IDX_W-1:0] r_idx;
    logic             fire;

    assign o_valid = i_valid;
    assign o_byte  = i_entry.data[r_idx];
    assign o_last  = (CNT_W'(r_idx) == i_entry.count - CNT_W'(1));
    assign fire    = i_valid && i_ready;
    assign o_pop   = fire && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= o_last ? '0 : r_idx + 1'b1;
        end
    end

endmodule

>>> rtl/core/base64_stream_codec.sv
// Streaming Base64 codec with the standard alphabet and '=' padding. The
// direction register (i_cfg_wdata, written with i_cfg_we; the user must
// write it only while the block is idle, the block does not enforce this;
// every write also clears the group state) selects encode (0: bytes in,
// characters out) or decode (1: characters in, bytes out). Requests are
// taken on i_in at one per cycle while the queue has room; a request that
// completes no character or byte produces nothing. Each encoded byte yields
// one or two characters, and the byte flagged in_last flushes the open
// group, so it can yield up to four. Decode yields at most one byte per
// character; after '=' in the third or fourth place of a group the rest of
// the message is dropped, and in_last always restarts the group. On o_out,
// out_last marks the final result of each input request. Output delivers
// one result per cycle while o_out.ready is high, so sustained input rate
// is bounded by results per request (for encode about 4/3 results per byte
// on long messages). A request's results are queued and offered from the head.
module base64_stream_codec
    import b64sc_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    b64sc_in_if.sink      i_in,
    b64sc_out_if.source   o_out
);

`include "assert_macros.svh"

    // Front: classifies each request and combinationally builds its full list
    // of results. Back: plays a list out one result per cycle while o_out.ready
    // is high. The small queue between them lets the front keep accepting while
    // the back is stalled on a multi-result flush or a busy consumer.
    t_entry front_entry;
    t_entry head_entry;
    logic   q_push;
    logic   q_push_ready;
    logic   q_valid;
    logic   q_pop;
    logic   entry_count_ok;
    logic   out_mid;

    b64sc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_byte       (i_in.in_byte),
        .i_last       (i_in.in_last),
        .o_push       (q_push),
        .i_push_ready (q_push_ready),
        .o_entry      (front_entry)
    );

    // The queue holds whole result lists, so one entry per request that yields results.
    b64sc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .o_push_ready (q_push_ready),
        .i_entry      (front_entry),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_entry      (head_entry)
    );

    // The back retires the head entry only once its final result is taken.
    b64sc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (head_entry),
        .o_pop    (q_pop),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_byte   (o_out.out_byte),
        .o_last   (o_out.out_last)
    );

    assign entry_count_ok = (front_entry.count != '0) &&
                            (front_entry.count <= CNT_W'(MAX_RESULTS));
    assign out_mid        = o_out.valid && o_out.ready && !o_out.out_last;

    // The front must never write an entry into a full queue.
    `ASSERT_SAME(a_no_push_full, q_push, q_push_ready, "push into full queue")
    // Every queued entry carries between one and four results.
    `ASSERT_SAME(a_push_count, q_push, entry_count_ok, "bad entry count")
    // A result that is not the last of its request is always followed by more.
    `ASSERT_NEXT(a_more_follows, out_mid, o_out.valid, "result list cut short")

endmodule
